>>> rtl/sbdp_pkg.sv
// Package with constants, types and helpers for the bank dump parser.
`default_nettype none

package sbdp_pkg;

  localparam int unsigned MessagesPerBank = 16;
  localparam int unsigned TonesPerMessage = 4;

  localparam int unsigned PosW    = 9;
  localparam int unsigned CountW  = 5;
  localparam int unsigned DataW   = 8;
  localparam int unsigned ToneW   = 6;
  localparam int unsigned OffsetW = 5;
  localparam int unsigned CharW   = 7;
  localparam int unsigned OutW    = 32;

  localparam logic [PosW-1:0]   ToneStart   = PosW'(9);
  localparam logic [PosW-1:0]   ToneEnd     = PosW'(9 + TonesPerMessage * 64);
  localparam logic [PosW:0]     MessageLen  = (PosW + 1)'(10 + TonesPerMessage * 64);
  localparam logic [PosW-1:0]   PosMax      = {PosW{1'b1}};
  localparam logic [CountW-1:0] CountMax    = {CountW{1'b1}};
  localparam logic [CountW-1:0] CountTarget = CountW'(MessagesPerBank);

  localparam logic [DataW-1:0] ByteSoxStart = 8'hF0;
  localparam logic [DataW-1:0] ByteSoxEnd   = 8'hF7;
  localparam logic [DataW-1:0] ByteMaker    = 8'h41;
  localparam logic [DataW-1:0] ByteModel    = 8'h37;
  localparam logic [DataW-1:0] ByteHdr4     = 8'h23;
  localparam logic [DataW-1:0] ByteHdr5     = 8'h20;
  localparam logic [DataW-1:0] ByteHdr6     = 8'h01;
  localparam logic [DataW-1:0] ByteHdr7     = 8'h00;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNCATED = 3'd1,
    ST_COUNT     = 3'd2,
    ST_LENGTH    = 3'd3,
    ST_MAKER     = 3'd4,
    ST_MODEL     = 3'd5,
    ST_HEADER    = 3'd6,
    ST_START     = 3'd7
  } status_t;

  typedef enum logic {
    KIND_TONE   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [ToneW-1:0]   tone;
    logic [OffsetW-1:0] offset;
    logic [DataW-1:0]   value;
    logic [CharW-1:0]   name_char;
    status_t            status;
    logic               last;
  } result_t;

  function automatic logic [CharW-1:0] name_ascii(input logic [5:0] code);
    logic [CharW-1:0] c;
    c = {1'b0, code};
    if (code <= 6'd25) begin
      name_ascii = 7'h41 + c;
    end else if (code <= 6'd51) begin
      name_ascii = 7'h61 + (c - 7'd26);
    end else if (code <= 6'd61) begin
      name_ascii = 7'h30 + (c - 7'd52);
    end else if (code == 6'd62) begin
      name_ascii = 7'h20;
    end else begin
      name_ascii = 7'h2D;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/sysex_bank_dump_parser.sv
// Top level of the bank dump parser: byte decode, message checks and result queue.
// Each result is registered into the result queue when its byte is accepted.
// One byte per cycle while the queue has room; a byte with two results fills two entries.
// A four-entry result queue accepts a byte whenever two entries are free.
// Reset (rst, synchronous, active high) clears the parser state and empties the queue.
`default_nettype none

module sysex_bank_dump_parser (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [sbdp_pkg::DataW-1:0] s_axis_tdata,  // data_byte
  input  wire logic                      s_axis_tlast,  // end_of_file
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // tone[5:0], offset[10:6], value[18:11], name_char[25:19], status[28:26], zero
  output logic [sbdp_pkg::OutW-1:0]      m_axis_tdata,
  output logic                           m_axis_tuser,  // kind
  output logic                           m_axis_tlast   // last
);
  import sbdp_pkg::*;

  logic              inside_message, inside_message_next;
  logic [PosW-1:0]   byte_position, byte_position_next;
  logic [CountW-1:0] message_count, message_count_next;
  logic [3:0]        low_nibble, low_nibble_next;
  status_t           pending_err, pending_err_next;
  status_t           first_err, first_err_next;

  result_t    queue [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;

  logic       in_fire, out_fire;
  logic [7:0] b;
  logic       eof;
  logic       tone_emit;
  result_t    tone_res, status_res;
  logic [1:0] n_push;

  logic [PosW-1:0] d;
  logic [7:0]      base_tone;
  status_t         hdr_err, close_err;
  logic [7:0]      byte_val;

  assign b        = s_axis_tdata;
  assign eof      = s_axis_tlast;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (count <= 3'd2);
  assign m_axis_tvalid = (count != 3'd0);

  always_comb begin
    inside_message_next = inside_message;
    byte_position_next  = byte_position;
    message_count_next  = message_count;
    low_nibble_next     = low_nibble;
    pending_err_next    = pending_err;
    first_err_next      = first_err;
    tone_emit           = 1'b0;
    d         = byte_position - ToneStart;
    base_tone = 8'(message_count * TonesPerMessage);
    byte_val  = {b[3:0], low_nibble};
    hdr_err   = ST_OK;
    close_err = ST_OK;

    tone_res           = '0;
    tone_res.kind      = KIND_TONE;
    tone_res.tone      = ToneW'(base_tone + 8'(d[PosW-1:6]));
    tone_res.offset    = d[5:1];
    tone_res.value     = byte_val;
    tone_res.name_char = (d[5:1] >= 5'd21 && d[5:1] <= 5'd30) ?
                         name_ascii(byte_val[5:0]) : '0;

    if (!inside_message) begin
      if (b == ByteSoxStart) begin
        inside_message_next = 1'b1;
        byte_position_next  = PosW'(1);
        low_nibble_next     = '0;
        pending_err_next    = ST_OK;
      end
    end else if (b == ByteSoxEnd) begin
      close_err = (({1'b0, byte_position} + 10'd1) != MessageLen) ? ST_LENGTH : pending_err;
      if (close_err != ST_OK && first_err == ST_OK) begin
        first_err_next = close_err;
      end
      if (message_count < CountMax) begin
        message_count_next = message_count + CountW'(1);
      end
      inside_message_next = 1'b0;
      byte_position_next  = '0;
      pending_err_next    = ST_OK;
    end else begin
      priority if (byte_position == PosW'(1) && b != ByteMaker) hdr_err = ST_MAKER;
      else if (byte_position == PosW'(2) && b != ByteModel) hdr_err = ST_MODEL;
      else if (byte_position == PosW'(4) && b != ByteHdr4) hdr_err = ST_HEADER;
      else if (byte_position == PosW'(5) && b != ByteHdr5) hdr_err = ST_HEADER;
      else if (byte_position == PosW'(6) && b != ByteHdr6) hdr_err = ST_HEADER;
      else if (byte_position == PosW'(7) && b != ByteHdr7) hdr_err = ST_HEADER;
      else if (byte_position == PosW'(8) && b != base_tone) hdr_err = ST_START;
      else hdr_err = ST_OK;
      if (hdr_err != ST_OK && pending_err == ST_OK) begin
        pending_err_next = hdr_err;
      end
      if (byte_position >= ToneStart && byte_position < ToneEnd) begin
        if (!d[0]) begin
          low_nibble_next = b[3:0];
        end else begin
          tone_emit = 1'b1;
        end
      end
      if (byte_position < PosMax) begin
        byte_position_next = byte_position + PosW'(1);
      end
    end

    status_res      = '0;
    status_res.kind = KIND_STATUS;
    status_res.last = 1'b1;
    if (inside_message_next) begin
      status_res.status = ST_TRUNCATED;
    end else if (message_count_next != CountTarget) begin
      status_res.status = ST_COUNT;
    end else begin
      status_res.status = first_err_next;
    end

    if (eof) begin
      inside_message_next = 1'b0;
      byte_position_next  = '0;
      message_count_next  = '0;
      low_nibble_next     = '0;
      pending_err_next    = ST_OK;
      first_err_next      = ST_OK;
    end

    n_push = in_fire ? ({1'b0, tone_emit} + {1'b0, eof}) : 2'd0;
  end

  always_comb begin
    count_next = count + {1'b0, n_push} - {2'b0, out_fire};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_message <= 1'b0;
      byte_position  <= '0;
      message_count  <= '0;
      low_nibble     <= '0;
      pending_err    <= ST_OK;
      first_err      <= ST_OK;
      wr_ptr         <= '0;
      rd_ptr         <= '0;
      count          <= '0;
    end else begin
      if (in_fire) begin
        inside_message <= inside_message_next;
        byte_position  <= byte_position_next;
        message_count  <= message_count_next;
        low_nibble     <= low_nibble_next;
        pending_err    <= pending_err_next;
        first_err      <= first_err_next;
      end
      wr_ptr <= wr_ptr + n_push;
      if (out_fire) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (tone_emit) begin
        queue[wr_ptr] <= tone_res;
        if (eof) begin
          queue[wr_ptr + 2'd1] <= status_res;
        end
      end else if (eof) begin
        queue[wr_ptr] <= status_res;
      end
    end
  end

  always_comb begin
    m_axis_tdata = {3'b000, queue[rd_ptr].status, queue[rd_ptr].name_char,
                    queue[rd_ptr].value, queue[rd_ptr].offset, queue[rd_ptr].tone};
    m_axis_tuser = queue[rd_ptr].kind;
    m_axis_tlast = queue[rd_ptr].last;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("result queue overflow");
  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && eof |=> !inside_message && message_count == '0 && first_err == ST_OK)
    else $error("state not cleared after last byte");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) + {1'b0, $past(n_push)} - {2'b0, $past(out_fire)})
    else $error("queue count mismatch");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    wr_ptr - rd_ptr == count[1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire
